FILE: rtl/rbma_pkg.sv
// Shared types and constants for the ring buffer moving average core.
// No dependencies; imported by the ALU, the sequencer and the top level.
package rbma_pkg;

  localparam int MAX_WINDOW = 32;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = 6;
  localparam int SAMPLE_W   = 32;
  // running sum of up to MAX_WINDOW samples, plus one bit for |sum| + half
  localparam int SUM_W      = SAMPLE_W + PTR_W + 1;
  localparam int DIV_STEPS  = SUM_W - 1;
  localparam int REM_W      = PTR_W;
  localparam int DIVC_W     = $clog2(DIV_STEPS);

  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_FILL  = 2'd2;

  typedef enum logic [2:0] {
    OP_HOLD  = 3'd0,
    OP_CLEAR = 3'd1,
    OP_ACC   = 3'd2,
    OP_ABS   = 3'd3,
    OP_HALF  = 3'd4,
    OP_DIV   = 3'd5,
    OP_SIGN  = 3'd6
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [CNT_W-1:0] count;
  } alu_ctl_t;

endpackage

FILE: rtl/rbma_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rbma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/rbma_alu.sv
// Shared adder datapath: sums samples, takes the magnitude, adds the rounding
// half, runs the restoring division and restores the sign. Uses rbma_pkg.
module rbma_alu
  import rbma_pkg::*;
(
  input  logic                clk,
  input  alu_ctl_t            ctl,
  input  logic [SAMPLE_W-1:0] rdata,
  output logic [SAMPLE_W-1:0] average
);

  logic [SUM_W-1:0] acc, acc_next;
  logic [REM_W-1:0] rem, rem_next;
  logic             neg, neg_next;
  logic [SUM_W-1:0] add_a, add_b, add_sum;
  logic             add_cin;
  logic [REM_W:0]   shifted;
  logic             ge;

  assign add_sum = add_a + add_b + SUM_W'(add_cin);
  assign shifted = {rem, acc[SUM_W-2]};

  always_comb begin
    add_a    = '0;
    add_b    = '0;
    add_cin  = 1'b0;
    ge       = 1'b0;
    acc_next = acc;
    rem_next = rem;
    neg_next = neg;
    case (ctl.op)
      OP_CLEAR: begin
        acc_next = '0;
        rem_next = '0;
        neg_next = 1'b0;
      end
      OP_ACC: begin
        add_a    = acc;
        add_b    = {{(SUM_W-SAMPLE_W){rdata[SAMPLE_W-1]}}, rdata};
        acc_next = add_sum;
      end
      OP_ABS: begin
        add_a    = ~acc;
        add_cin  = 1'b1;
        neg_next = acc[SUM_W-1];
        if (acc[SUM_W-1]) begin
          acc_next = add_sum;
        end
      end
      OP_HALF: begin
        add_a    = acc;
        add_b    = SUM_W'(ctl.count[CNT_W-1:1]);
        acc_next = add_sum;
        rem_next = '0;
      end
      OP_DIV: begin
        // one quotient bit per step; quotient shifts in from the bottom
        add_a    = SUM_W'(shifted);
        add_b    = ~SUM_W'(ctl.count);
        add_cin  = 1'b1;
        ge       = ~add_sum[SUM_W-1];
        rem_next = ge ? add_sum[REM_W-1:0] : shifted[REM_W-1:0];
        acc_next = {1'b0, acc[SUM_W-3:0], ge};
      end
      OP_SIGN: begin
        add_a   = ~acc;
        add_cin = 1'b1;
        if (neg) begin
          acc_next = add_sum;
        end
      end
      default: begin
        acc_next = acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
    rem <= rem_next;
    neg <= neg_next;
  end

  assign average = acc[SAMPLE_W-1:0];

endmodule

FILE: rtl/rbma_ctrl.sv
// Sequencer: window pointer and full flag, fill sweep, sum read-out and
// division step count; drives the RAM and the shared ALU. Uses rbma_pkg.
module rbma_ctrl
  import rbma_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CNT_W-1:0]    cfg_wdata,
  input  logic                in_accept,
  input  logic [1:0]          in_action,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                out_load,
  output logic                idle,
  output logic                done,
  output logic                full,
  output alu_ctl_t            alu_ctl,
  output logic                ram_we,
  output logic [PTR_W-1:0]    ram_waddr,
  output logic [SAMPLE_W-1:0] ram_wdata,
  output logic [PTR_W-1:0]    ram_raddr
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_FILL = 9'b000000010,
    ST_PREP = 9'b000000100,
    ST_SUM  = 9'b000001000,
    ST_ABS  = 9'b000010000,
    ST_HALF = 9'b000100000,
    ST_DIV  = 9'b001000000,
    ST_SIGN = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_t;

  state_t              state, state_next;
  logic [PTR_W-1:0]    ptr, ptr_next;
  logic                full_next;
  logic [CNT_W-1:0]    wlen;
  logic [CNT_W-1:0]    len_eff;
  logic [CNT_W-1:0]    held;
  logic [CNT_W-1:0]    count, count_next;
  logic [CNT_W-1:0]    idx, idx_next;
  logic [DIVC_W-1:0]   step, step_next;
  logic                pend, pend_next;
  logic [SAMPLE_W-1:0] val;
  logic                issue;

  always_comb begin
    if (wlen == '0) begin
      len_eff = CNT_W'(1);
    end else if (wlen > CNT_W'(MAX_WINDOW)) begin
      len_eff = CNT_W'(MAX_WINDOW);
    end else begin
      len_eff = wlen;
    end
    if (full) begin
      held = len_eff;
    end else if (CNT_W'(ptr) < len_eff) begin
      held = CNT_W'(ptr);
    end else begin
      held = len_eff;
    end
  end

  assign issue = (idx != count);

  always_comb begin
    state_next    = state;
    ptr_next      = ptr;
    full_next     = full;
    count_next    = count;
    idx_next      = idx;
    step_next     = step;
    pend_next     = pend;
    alu_ctl.op    = OP_HOLD;
    alu_ctl.count = count;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_PREP;
          case (in_action)
            ACT_PUSH: begin
              if (CNT_W'(ptr) >= len_eff - CNT_W'(1)) begin
                full_next = 1'b1;
                ptr_next  = '0;
              end else begin
                ptr_next = ptr + PTR_W'(1);
              end
            end
            ACT_CLEAR: begin
              ptr_next  = '0;
              full_next = 1'b0;
            end
            ACT_FILL: begin
              ptr_next   = '0;
              full_next  = 1'b1;
              idx_next   = '0;
              state_next = ST_FILL;
            end
            default: begin
              state_next = ST_PREP;
            end
          endcase
        end
      end
      ST_FILL: begin
        idx_next = idx + CNT_W'(1);
        if (idx == len_eff - CNT_W'(1)) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        alu_ctl.op = OP_CLEAR;
        count_next = held;
        idx_next   = '0;
        pend_next  = 1'b0;
        state_next = (held == '0) ? ST_OUT : ST_SUM;
      end
      ST_SUM: begin
        // read issued one cycle, data added the next
        alu_ctl.op = pend ? OP_ACC : OP_HOLD;
        pend_next  = issue;
        if (issue) begin
          idx_next = idx + CNT_W'(1);
        end else if (!pend) begin
          state_next = ST_ABS;
        end
      end
      ST_ABS: begin
        alu_ctl.op = OP_ABS;
        state_next = ST_HALF;
      end
      ST_HALF: begin
        alu_ctl.op = OP_HALF;
        step_next  = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        alu_ctl.op = OP_DIV;
        step_next  = step + DIVC_W'(1);
        if (step == DIVC_W'(DIV_STEPS - 1)) begin
          state_next = ST_SIGN;
        end
      end
      ST_SIGN: begin
        alu_ctl.op = OP_SIGN;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ptr   <= '0;
      full  <= 1'b0;
      wlen  <= CNT_W'(MAX_WINDOW);
      pend  <= 1'b0;
      count <= '0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      full  <= full_next;
      pend  <= pend_next;
      count <= count_next;
      if (cfg_we) begin
        wlen <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    step <= step_next;
    if (in_accept) begin
      val <= in_sample;
    end
  end

  assign idle = (state == ST_IDLE);
  assign done = (state == ST_OUT);

  always_comb begin
    if (state == ST_FILL) begin
      ram_we    = 1'b1;
      ram_waddr = idx[PTR_W-1:0];
      ram_wdata = val;
    end else begin
      ram_we    = in_accept && (in_action == ACT_PUSH);
      ram_waddr = ptr;
      ram_wdata = in_sample;
    end
  end

  assign ram_raddr = idx[PTR_W-1:0];

endmodule

FILE: rtl/ring_buffer_moving_average_core.sv
// Ring buffer moving average: top level with stream ports and output register.
// Push and clear step from accept through sum, magnitude, rounding, division and
// sign; fill first adds a write sweep, and an empty window goes straight to output.
// One item at a time; the rate is set by the one-read-per-cycle sum over the
// sample RAM and the 37-step restoring division on the shared adder.
// Reset (rst, synchronous): window empty, pointer 0, window_length 32.
module ring_buffer_moving_average_core
  import rbma_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CNT_W-1:0]    cfg_wdata,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,   // [31:0] sample_value
  input  logic [1:0]          s_tuser,   // [1:0] action
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [39:0]         m_tdata    // [31:0] average, [37:32] held_count,
                                         // [38] window_full, [39] zero
);

  logic                s_accept;
  logic                idle, done, full, out_load;
  alu_ctl_t            alu_ctl;
  logic                ram_we;
  logic [PTR_W-1:0]    ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;
  logic [SAMPLE_W-1:0] average;
  logic [SAMPLE_W-1:0] avg_q;
  logic [CNT_W-1:0]    held_q;
  logic                full_q;

  assign s_tready = idle;
  assign s_accept = s_tvalid && s_tready;
  assign out_load = done && (!m_tvalid || m_tready);

  rbma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_accept (s_accept),
    .in_action (s_tuser),
    .in_sample (s_tdata),
    .out_load  (out_load),
    .idle      (idle),
    .done      (done),
    .full      (full),
    .alu_ctl   (alu_ctl),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr)
  );

  rbma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rbma_alu u_alu (
    .clk     (clk),
    .ctl     (alu_ctl),
    .rdata   (ram_rdata),
    .average (average)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      avg_q  <= average;
      held_q <= alu_ctl.count;
      full_q <= full;
    end
  end

  assign m_tdata = {1'b0, full_q, held_q, avg_q};

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> !s_tready)
    else $error("input accepted while an item is in progress");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[37:32] <= CNT_W'(MAX_WINDOW)))
    else $error("held count beyond window size");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[37:32] == '0)) |-> ((m_tdata[31:0] == '0) && !m_tdata[38]))
    else $error("empty window must report zero average and not full");
`endif

endmodule
